### sv/ibss_pkg.sv
// Shared types and constants for the indexed byte sequence store.
package ibss_pkg;

  // Count and index width, wide enough for the largest supported capacity (1024).
  localparam int CNT_W = 11;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_INSERT_AT  = 3'd4,
    REQ_ERASE_AT   = 3'd5,
    REQ_FIND       = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_RANGE     = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_ERASE,
    OP_FIND
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REDUCE,
    S_RESULT
  } state_e;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic             en;
    op_e              op;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    logic [CNT_W-1:0] cnt_new;
    logic [7:0]       value;
  } ctl_t;

endpackage

### sv/ibss_if.sv
// Request and response channel interfaces of the indexed byte sequence store.
interface ibss_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [6:0] position;
  logic [7:0] value;

  modport source (output valid, req_type, position, value, input ready);
  modport sink (input valid, req_type, position, value, output ready);
endinterface

interface ibss_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] entry_count;
  logic [7:0] front_byte;
  logic [7:0] back_byte;

  modport source (output valid, status, entry_count, front_byte, back_byte, input ready);
  modport sink (input valid, status, entry_count, front_byte, back_byte, output ready);
endinterface

### sv/ibss_cell.sv
// One storage cell of the shifting chain: a byte, an end-of-sequence flag and a match flag.
module ibss_cell #(
  parameter int INDEX = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  ibss_pkg::ctl_t ctl,
  input  logic [7:0]    left_data,
  input  logic [7:0]    right_data,
  output logic [7:0]    data,
  output logic          last,
  output logic          hit
);
  import ibss_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

  logic [7:0] data_next;
  logic       occupied;

  assign occupied = IDX < ctl.cnt;

  always_comb begin
    data_next = data;
    unique case (ctl.op)
      OP_INSERT: begin
        if (IDX == ctl.pos) begin
          data_next = ctl.value;
        end else if (IDX > ctl.pos && IDX <= ctl.cnt) begin
          data_next = left_data;
        end
      end
      OP_ERASE: begin
        // Cells past the new end keep stale bytes; they are never read.
        if (IDX >= ctl.pos && (IDX + CNT_W'(1)) < ctl.cnt) begin
          data_next = right_data;
        end
      end
      OP_FIND, OP_NONE: data_next = data;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      data <= data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last <= 1'b0;
      hit  <= 1'b0;
    end else if (ctl.en) begin
      last <= (ctl.cnt_new != '0) && (IDX == ctl.cnt_new - CNT_W'(1));
      hit  <= (ctl.op == OP_FIND) && occupied && (data == ctl.value);
    end
  end

endmodule

### sv/indexed_byte_sequence_store.sv
// Top level of the indexed byte sequence store: request decode, cell chain, result reduction.
//
//   channel  direction  transfer carries
//   req      in         req_type, position, value
//   rsp      out        status, entry_count, front_byte, back_byte
//
// The cell chain updates at the request transfer edge. A registered OR over groups of 32
// cells follows in the next cycle, and an OR across groups feeds the response register
// after it. req is ready only in idle, so a new request is not taken while one is in flight.
// A stalled response holds the reduction stage; the next request is taken once the
// response register has been loaded. Synchronous reset empties the sequence at once.
module indexed_byte_sequence_store #(
  parameter int CAPACITY = 64
) (
  input  logic clk,
  input  logic rst,
  ibss_req_if.sink   req,
  ibss_rsp_if.source rsp
);
  import ibss_pkg::*;

  localparam int GRP = 32;
  localparam int NG  = (CAPACITY + GRP - 1) / GRP;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  state_e state, state_next;

  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] pos_ext;
  status_e          status_now;
  status_e          pend_status;
  logic             pend_find;
  ctl_t             ctl;
  logic             accept;

  logic [7:0] cell_data [CAPACITY];
  logic       cell_last [CAPACITY];
  logic       cell_hit  [CAPACITY];

  logic       grp_hit        [NG];
  logic [7:0] grp_back       [NG];
  logic       grp_hit_next   [NG];
  logic [7:0] grp_back_next  [NG];

  logic       any_hit;
  logic [7:0] back_or;
  logic       load_out;

  logic       out_valid;
  status_e    out_status;
  logic [6:0] out_count;
  logic [7:0] out_front;
  logic [7:0] out_back;

  assign accept  = req.valid && req.ready;
  assign pos_ext = CNT_W'(req.position);

  // Decode the request into one chain operation and its status.
  always_comb begin
    ctl         = '0;
    ctl.en      = accept;
    ctl.cnt     = count;
    ctl.value   = req.value;
    ctl.op      = OP_NONE;
    ctl.pos     = '0;
    status_now  = ST_OK;
    count_next  = count;
    unique case (req_e'(req.req_type))
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (count >= CAP) begin
          status_now = ST_FULL;
        end else begin
          ctl.op     = OP_INSERT;
          ctl.pos    = (req_e'(req.req_type) == REQ_PUSH_FRONT) ? '0 : count;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (count == '0) begin
          status_now = ST_EMPTY;
        end else begin
          ctl.op     = OP_ERASE;
          ctl.pos    = (req_e'(req.req_type) == REQ_POP_FRONT) ? '0 : count - CNT_W'(1);
          count_next = count - CNT_W'(1);
        end
      end
      REQ_INSERT_AT: begin
        priority if (pos_ext > count) begin
          status_now = ST_RANGE;
        end else if (count >= CAP) begin
          status_now = ST_FULL;
        end else begin
          ctl.op     = OP_INSERT;
          ctl.pos    = pos_ext;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_ERASE_AT: begin
        if (pos_ext >= count) begin
          status_now = ST_RANGE;
        end else begin
          ctl.op     = OP_ERASE;
          ctl.pos    = pos_ext;
          count_next = count - CNT_W'(1);
        end
      end
      REQ_FIND: ctl.op = OP_FIND;
      REQ_CLEAR: count_next = '0;
      default: ctl.op = OP_NONE;
    endcase
    ctl.cnt_new = count_next;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [7:0] left_in;
    logic [7:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = req.value;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end
    ibss_cell #(.INDEX(i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .last       (cell_last[i]),
      .hit        (cell_hit[i])
    );
  end

  // First reduction stage: OR within groups of 32 cells.
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_hit_next[g]  = 1'b0;
      grp_back_next[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_hit_next[g]  = grp_hit_next[g] | cell_hit[g*GRP+k];
          grp_back_next[g] = grp_back_next[g] | (cell_data[g*GRP+k] & {8{cell_last[g*GRP+k]}});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_REDUCE) begin
      for (int g = 0; g < NG; g++) begin
        grp_hit[g]  <= grp_hit_next[g];
        grp_back[g] <= grp_back_next[g];
      end
    end
  end

  // Second reduction stage: OR across groups.
  always_comb begin
    any_hit = 1'b0;
    back_or = '0;
    for (int g = 0; g < NG; g++) begin
      any_hit = any_hit | grp_hit[g];
      back_or = back_or | grp_back[g];
    end
  end

  assign load_out = (state == S_RESULT) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = S_REDUCE;
        end
      end
      S_REDUCE: state_next = S_RESULT;
      S_RESULT: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_now;
      pend_find   <= (req_e'(req.req_type) == REQ_FIND);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= pend_find ? (any_hit ? ST_OK : ST_NOT_FOUND) : pend_status;
      out_count  <= count[6:0];
      out_front  <= (count != '0) ? cell_data[0] : '0;
      out_back   <= (count != '0) ? back_or : '0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.entry_count = out_count;
  assign rsp.front_byte  = out_front;
  assign rsp.back_byte   = out_back;

endmodule

### tb/tb_top.sv
// Self-checking testbench for the indexed byte sequence store: directed table, then random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ibss_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX = 10;

  // Per-phase pacing in percent: sender idle, then receiver idle.
  localparam int SEND_IDLE [3] = '{28, 49, 0};
  localparam int RECV_IDLE [3] = '{49, 28, 0};
  localparam int PHASE_ITEMS [3] = '{534, 533, 533};

  // Request mix per traffic mode (grow, shrink, mixed), in req_e order, each row sums to 100.
  localparam int OP_WEIGHT [3][8] = '{
    '{18, 18, 4, 4, 30, 6, 18, 2},
    '{5, 5, 18, 18, 8, 28, 16, 2},
    '{12, 12, 12, 12, 15, 15, 20, 2}
  };

  typedef struct packed {
    status_e    status;
    logic [6:0] entry_count;
    logic [7:0] front_byte;
    logic [7:0] back_byte;
  } store_view_t;

  typedef struct packed {
    req_e        op;
    logic [6:0]  pos;
    logic [7:0]  val;
    logic        pinned;
    store_view_t view;
  } stim_row_t;

  logic clk;
  logic rst;

  ibss_req_if req_ch ();
  ibss_rsp_if rsp_ch ();

  indexed_byte_sequence_store #(
    .CAPACITY(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Predicted contents of the store, index 0 at the front.
  logic [7:0]  stored_bytes[$];
  store_view_t pending_views[$];

  int send_idle_pct = SEND_IDLE[0];
  int recv_idle_pct = RECV_IDLE[0];
  int mismatch_count = 0;
  int items_sent = 0;
  int responses_seen = 0;
  int peak_count = 0;
  int idle_cycles = 0;
  int status_seen [5] = '{0, 0, 0, 0, 0};

  // Rows with the pinned bit set carry a result that is plain from the request history.
  stim_row_t directed_rows [24] = '{
    '{REQ_POP_FRONT, 7'd0,   8'h00, 1'b1, '{ST_EMPTY,     7'd0, 8'h00, 8'h00}},
    '{REQ_POP_BACK,  7'd0,   8'h00, 1'b1, '{ST_EMPTY,     7'd0, 8'h00, 8'h00}},
    '{REQ_ERASE_AT,  7'd0,   8'h00, 1'b1, '{ST_RANGE,     7'd0, 8'h00, 8'h00}},
    '{REQ_FIND,      7'd0,   8'h00, 1'b1, '{ST_NOT_FOUND, 7'd0, 8'h00, 8'h00}},
    '{REQ_INSERT_AT, 7'd1,   8'h55, 1'b1, '{ST_RANGE,     7'd0, 8'h00, 8'h00}},
    '{REQ_INSERT_AT, 7'd127, 8'hAA, 1'b1, '{ST_RANGE,     7'd0, 8'h00, 8'h00}},
    '{REQ_INSERT_AT, 7'd0,   8'hFF, 1'b1, '{ST_OK,        7'd1, 8'hFF, 8'hFF}},
    '{REQ_PUSH_FRONT, 7'd0,  8'h00, 1'b1, '{ST_OK,        7'd2, 8'h00, 8'hFF}},
    '{REQ_PUSH_BACK, 7'd0,   8'h80, 1'b1, '{ST_OK,        7'd3, 8'h00, 8'h80}},
    '{REQ_FIND,      7'd0,   8'hFF, 1'b1, '{ST_OK,        7'd3, 8'h00, 8'h80}},
    '{REQ_FIND,      7'd0,   8'h7F, 1'b1, '{ST_NOT_FOUND, 7'd3, 8'h00, 8'h80}},
    '{REQ_INSERT_AT, 7'd3,   8'h7F, 1'b1, '{ST_OK,        7'd4, 8'h00, 8'h7F}},
    '{REQ_ERASE_AT,  7'd4,   8'h00, 1'b1, '{ST_RANGE,     7'd4, 8'h00, 8'h7F}},
    '{REQ_ERASE_AT,  7'd1,   8'h00, 1'b1, '{ST_OK,        7'd3, 8'h00, 8'h7F}},
    '{REQ_POP_FRONT, 7'd0,   8'h00, 1'b1, '{ST_OK,        7'd2, 8'h80, 8'h7F}},
    '{REQ_POP_BACK,  7'd0,   8'h00, 1'b1, '{ST_OK,        7'd1, 8'h80, 8'h80}},
    '{REQ_CLEAR,     7'd127, 8'hFF, 1'b1, '{ST_OK,        7'd0, 8'h00, 8'h00}},
    '{REQ_PUSH_BACK, 7'd0,   8'h5A, 1'b0, '0},
    '{REQ_PUSH_BACK, 7'd0,   8'hA5, 1'b0, '0},
    '{REQ_INSERT_AT, 7'd1,   8'h3C, 1'b0, '0},
    '{REQ_FIND,      7'd0,   8'h3C, 1'b0, '0},
    '{REQ_ERASE_AT,  7'd2,   8'h00, 1'b0, '0},
    '{REQ_POP_FRONT, 7'd0,   8'h00, 1'b0, '0},
    '{REQ_ERASE_AT,  7'd127, 8'h00, 1'b0, '0}
  };

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Applies one request to the predicted contents and returns the response it should produce.
  function automatic store_view_t apply_request(req_e op, logic [6:0] pos, logic [7:0] v);
    store_view_t view;
    int          fill;
    fill = stored_bytes.size();
    view.status = ST_OK;
    case (op)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (fill >= STORE_DEPTH) view.status = ST_FULL;
        else if (op == REQ_PUSH_FRONT) stored_bytes.push_front(v);
        else stored_bytes.insert(fill, v);
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (fill == 0) view.status = ST_EMPTY;
        else if (op == REQ_POP_FRONT) void'(stored_bytes.pop_front());
        else void'(stored_bytes.pop_back());
      end
      REQ_INSERT_AT: begin
        // The range check wins over the full check.
        if (int'(pos) > fill) view.status = ST_RANGE;
        else if (fill >= STORE_DEPTH) view.status = ST_FULL;
        else stored_bytes.insert(int'(pos), v);
      end
      REQ_ERASE_AT: begin
        if (int'(pos) >= fill) view.status = ST_RANGE;
        else stored_bytes.delete(int'(pos));
      end
      REQ_FIND: begin
        view.status = ST_NOT_FOUND;
        foreach (stored_bytes[k]) if (stored_bytes[k] == v) view.status = ST_OK;
      end
      default: stored_bytes.delete();
    endcase
    fill = stored_bytes.size();
    view.entry_count = 7'(fill);
    view.front_byte = (fill != 0) ? stored_bytes[0] : 8'h00;
    view.back_byte = (fill != 0) ? stored_bytes[fill - 1] : 8'h00;
    return view;
  endfunction

  function automatic string show_view(store_view_t view);
    return $sformatf("status %0d count %0d front %02h back %02h",
                     view.status, view.entry_count, view.front_byte, view.back_byte);
  endfunction

  task automatic send_req(input req_e op, input logic [6:0] pos, input logic [7:0] val,
                          input logic pinned, input store_view_t pin_view);
    store_view_t predicted;
    @(negedge clk);
    // Idle cycles carry junk payload so the block must qualify it with valid.
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= 3'($urandom);
      req_ch.position <= 7'($urandom);
      req_ch.value <= 8'($urandom);
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= op;
    req_ch.position <= pos;
    req_ch.value <= val;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_request(op, pos, val);
    pending_views.insert(pending_views.size(), pinned ? pin_view : predicted);
    items_sent++;
    if (stored_bytes.size() > peak_count) peak_count = stored_bytes.size();
  endtask

  // Holds off new requests until every outstanding response has been checked.
  task automatic wait_for_drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      store_view_t got;
      store_view_t want;
      got.status = status_e'(rsp_ch.status);
      got.entry_count = rsp_ch.entry_count;
      got.front_byte = rsp_ch.front_byte;
      got.back_byte = rsp_ch.back_byte;
      responses_seen++;
      if (rsp_ch.status < 3'd5) status_seen[rsp_ch.status]++;
      if (pending_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: response with nothing outstanding: %s", $realtime, show_view(got));
      end else begin
        want = pending_views.pop_front();
        if (got.status !== want.status || got.entry_count !== want.entry_count ||
            got.front_byte !== want.front_byte || got.back_byte !== want.back_byte) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("%0t: response %0d expected %s, got %s", $realtime, responses_seen,
                     show_view(want), show_view(got));
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d responses outstanding", $realtime,
               idle_cycles, pending_views.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int          mode;
    int          burst_left;
    int          roll;
    int          acc;
    int          fill;
    req_e        op;
    logic [6:0]  pos;
    logic [7:0]  val;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_PUSH_FRONT;
    req_ch.position = 7'd0;
    req_ch.value = 8'h00;
    rsp_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_req(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
               directed_rows[i].pinned, directed_rows[i].view);
    wait_for_drain();

    mode = 0;
    burst_left = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = SEND_IDLE[phase];
      recv_idle_pct = RECV_IDLE[phase];
      for (int n = 0; n < PHASE_ITEMS[phase]; n++) begin
        // Bursts of one traffic mode let the store fill up and drain out completely.
        if (burst_left == 0) begin
          mode = $urandom_range(2);
          burst_left = $urandom_range(20, 120);
        end
        burst_left--;
        roll = $urandom_range(99);
        acc = 0;
        op = REQ_CLEAR;
        for (int k = 0; k < 8; k++) begin
          acc += OP_WEIGHT[mode][k];
          if (roll < acc) begin
            op = req_e'(3'(k));
            break;
          end
        end
        fill = stored_bytes.size();
        pos = 7'($urandom_range(127));
        if (op == REQ_INSERT_AT && $urandom_range(99) < 85)
          pos = 7'($urandom_range(fill));
        else if (op == REQ_ERASE_AT && fill != 0 && $urandom_range(99) < 85)
          pos = 7'($urandom_range(fill - 1));
        val = 8'($urandom_range(255));
        if (op == REQ_FIND && fill != 0 && $urandom_range(1) == 1)
          val = stored_bytes[$urandom_range(fill - 1)];
        send_req(op, pos, val, 1'b0, '0);
      end
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d responses to %0d requests (%0d directed); fill peaked at %0d of %0d.",
             responses_seen, items_sent, $size(directed_rows), peak_count, STORE_DEPTH);
    $display("Statuses seen: ok %0d, empty %0d, out of range %0d, full %0d, not found %0d.",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (mismatch_count == 0 && pending_views.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
